// ===== sv/bmi_pkg.sv =====
// ----------------------------------------------------------------------------
// bmi_pkg: shared definitions of the batch modular inverse core
// Widths, state codes and the request and response types of the modular
// arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bmi_pkg;

  localparam int MAX_LEN    = 64;
  localparam int VALUE_BITS = 60;
  localparam int IDX_W      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W      = $clog2(VALUE_BITS);
  localparam int COUNT_W    = $clog2(MAX_LEN + 1);

  localparam logic [VALUE_BITS-1:0] MODULUS_RESET = VALUE_BITS'(65537);

  typedef logic [VALUE_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    OP_DIV,
    OP_MUL
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
    word_t     x;
    word_t     y;
    word_t     m;
  } arith_req_t;

  typedef struct packed {
    logic  done;
    word_t rem;
    word_t quot;
  } arith_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RED_V_W,
    S_WR_ELEM,
    S_PRE_RD,
    S_RED_P_W,
    S_MUL_P_W,
    S_WR_PRE,
    S_INV_CHK,
    S_INV_DIV_W,
    S_INV_MUL_W,
    S_BK,
    S_BK_PRD,
    S_BK_M1,
    S_BK_ERD,
    S_BK_M2,
    S_EMIT_RD,
    S_EMIT_LD
  } state_e;

endpackage

`default_nettype wire

// ===== sv/bmi_if.sv =====
// ----------------------------------------------------------------------------
// bmi_in_if / bmi_out_if: channels of the batch modular inverse core
// Valid and ready handshake with the payload of one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmi_in_if;
  logic                 valid;
  logic                 ready;
  bmi_pkg::word_t       value;
  logic                 last_in;

  modport source (output valid, value, last_in, input ready);
  modport sink   (input valid, value, last_in, output ready);
endinterface

interface bmi_out_if;
  logic                 valid;
  logic                 ready;
  bmi_pkg::word_t       inverse;
  logic                 not_invertible;
  logic                 last_out;

  modport source (output valid, inverse, not_invertible, last_out, input ready);
  modport sink   (input valid, inverse, not_invertible, last_out, output ready);
endinterface

`default_nettype wire

// ===== sv/bmi_arith.sv =====
// ----------------------------------------------------------------------------
// bmi_arith: bit-serial modular arithmetic unit
// Restoring division (quotient and remainder, one bit a cycle) and
// shift-and-add modular multiplication (a doubling step and an add step a bit).
// ----------------------------------------------------------------------------
`default_nettype none

module bmi_arith (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  bmi_pkg::arith_req_t  req_i,
  output bmi_pkg::arith_rsp_t  rsp_o
);

  localparam int VB = bmi_pkg::VALUE_BITS;

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic                       phase_q, phase_d;
  logic [bmi_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  bmi_pkg::arith_op_e         op_q, op_d;
  bmi_pkg::word_t             x_q, x_d, y_q, y_d, m_q, m_d, acc_q, acc_d;

  logic [VB:0] rem_sh, div_sub, dbl, dbl_sub, sum, sum_sub;
  logic        last_step;

  // Datapath of one step for either operation.
  always_comb begin
    rem_sh  = {acc_q, x_q[VB-1]};
    div_sub = rem_sh - {1'b0, y_q};
    dbl     = {acc_q, 1'b0};
    dbl_sub = dbl - {1'b0, m_q};
    sum     = {1'b0, acc_q} + {1'b0, y_q};
    sum_sub = sum - {1'b0, m_q};
    last_step = (cnt_q == bmi_pkg::CNT_W'(VB - 1)) &&
                ((op_q == bmi_pkg::OP_DIV) || phase_q);
  end

  // Step sequencing.
  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    op_d    = op_q;
    x_d     = x_q;
    y_d     = y_q;
    m_d     = m_q;
    acc_d   = acc_q;
    done_d  = busy_q && last_step;
    if (!busy_q) begin
      if (req_i.start) begin
        busy_d  = 1'b1;
        phase_d = 1'b0;
        cnt_d   = '0;
        op_d    = req_i.op;
        x_d     = req_i.x;
        y_d     = req_i.y;
        m_d     = req_i.m;
        acc_d   = '0;
      end
    end else begin
      case (op_q)
        bmi_pkg::OP_DIV: begin
          if (rem_sh >= {1'b0, y_q}) begin
            acc_d = div_sub[VB-1:0];
            x_d   = {x_q[VB-2:0], 1'b1};
          end else begin
            acc_d = rem_sh[VB-1:0];
            x_d   = {x_q[VB-2:0], 1'b0};
          end
          cnt_d = cnt_q + 1'b1;
        end
        bmi_pkg::OP_MUL: begin
          if (!phase_q) begin
            acc_d   = (dbl >= {1'b0, m_q}) ? dbl_sub[VB-1:0] : dbl[VB-1:0];
            phase_d = 1'b1;
          end else begin
            if (x_q[VB-1]) begin
              acc_d = (sum >= {1'b0, m_q}) ? sum_sub[VB-1:0] : sum[VB-1:0];
            end
            x_d     = {x_q[VB-2:0], 1'b0};
            phase_d = 1'b0;
            cnt_d   = cnt_q + 1'b1;
          end
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
      if (last_step) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
      op_q    <= bmi_pkg::OP_DIV;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      op_q    <= op_d;
    end
  end

  // Operand and accumulator registers.
  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    m_q   <= m_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = acc_q;
  assign rsp_o.quot = x_q;

endmodule

`default_nettype wire

// ===== sv/batch_modular_inverse_core.sv =====
// ----------------------------------------------------------------------------
// batch_modular_inverse_core: batch modular inversion of a residue vector
// Keeps elements and prefix products, inverts the full product once and
// derives every element's inverse in a backward pass.
// ----------------------------------------------------------------------------
// Usage: elements arrive on in_i, one per transaction, last_in closing the
// vector (the 64th element closes it in any case). Results leave on out_o
// in input order, last_out on the final one. The modulus is written through
// cfg_we_i / cfg_wdata_i by the user only while the block is idle; the block
// itself does not enforce this. The first element of a vector takes a 60-bit
// reduction on the bit-serial arithmetic unit plus memory writes; every
// later element takes a reduction of the element, a reduction of the
// previous prefix product, the shift-and-add multiply and the control and
// memory accesses. With a modulus below two an element skips the arithmetic.
// The closing element adds the inversion, one division and one multiply per
// Euclid step, then the backward pass over the elements, then the results
// while the receiver is ready.
// in_i.ready is high only in the idle state between elements; it is low
// while an element is processed, during the inversion, the backward pass
// and result output. A stalled receiver holds the output register; the
// final result may wait there while the next element loads.
// Reset sets the modulus to 65537 and empties the open vector; the element,
// prefix and result memories need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module batch_modular_inverse_core (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire [bmi_pkg::VALUE_BITS-1:0] cfg_wdata_i,
  bmi_in_if.sink                      in_i,
  bmi_out_if.source                   out_o
);

  localparam int VB = bmi_pkg::VALUE_BITS;
  localparam int IW = bmi_pkg::IDX_W;

  bmi_pkg::state_e             state_q, state_d;
  logic [bmi_pkg::COUNT_W-1:0] count_q, count_d;
  bmi_pkg::word_t              modulus_q, modulus_d;

  bmi_pkg::word_t  v_q, v_d, m_q, m_d, p_q, p_d;
  bmi_pkg::word_t  r0_q, r0_d, r1_q, r1_d, t0_q, t0_d, t1_q, t1_d;
  bmi_pkg::word_t  nr_q, nr_d, aux_q, aux_d;
  logic            last_q, last_d, ok_q, ok_d, err_q, err_d;
  logic [IW-1:0]   idx_q, idx_d, i_q, i_d, e_q, e_d;

  logic            out_valid_q, out_valid_d, out_err_q, out_err_d;
  logic            out_last_q, out_last_d;
  bmi_pkg::word_t  out_inv_q, out_inv_d;

  bmi_pkg::arith_req_t areq;
  bmi_pkg::arith_rsp_t arsp;

  // Memories.
  bmi_pkg::word_t elem_mem [bmi_pkg::MAX_LEN];
  bmi_pkg::word_t pre_mem  [bmi_pkg::MAX_LEN];
  bmi_pkg::word_t res_mem  [bmi_pkg::MAX_LEN];

  logic           elem_we, elem_re, pre_we, pre_re, res_we, res_re;
  logic [IW-1:0]  elem_waddr, elem_raddr, pre_waddr, pre_raddr;
  logic [IW-1:0]  res_waddr, res_raddr;
  bmi_pkg::word_t elem_wdata, pre_wdata, res_wdata;
  bmi_pkg::word_t elem_rdata_q, pre_rdata_q, res_rdata_q;

  logic           in_acc, closing;
  logic [VB:0]    nt_wide;
  bmi_pkg::word_t nt;

  bmi_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (areq),
    .rsp_o  (arsp)
  );

  assign in_acc = in_i.valid && in_i.ready;
  assign closing = last_q || (idx_q == IW'(bmi_pkg::MAX_LEN - 1));

  // Next coefficient of the extended Euclid step, t0 - q * t1 modulo m.
  always_comb begin
    if (t0_q >= arsp.rem) begin
      nt_wide = {1'b0, t0_q} - {1'b0, arsp.rem};
    end else begin
      nt_wide = {1'b0, t0_q} + {1'b0, m_q} - {1'b0, arsp.rem};
    end
    nt = nt_wide[VB-1:0];
  end

  // Sequencer: load, inversion, backward pass and result output.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    modulus_d = cfg_we_i ? cfg_wdata_i : modulus_q;
    v_d = v_q;  m_d = m_q;  p_d = p_q;
    r0_d = r0_q; r1_d = r1_q; t0_d = t0_q; t1_d = t1_q;
    nr_d = nr_q; aux_d = aux_q;
    last_d = last_q; ok_d = ok_q; err_d = err_q;
    idx_d = idx_q; i_d = i_q; e_d = e_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_inv_d = out_inv_q;
    out_err_d = out_err_q;
    out_last_d = out_last_q;

    areq.start = 1'b0;
    areq.op    = bmi_pkg::OP_DIV;
    areq.x     = '0;
    areq.y     = '0;
    areq.m     = m_q;

    elem_we = 1'b0; elem_waddr = idx_q; elem_wdata = v_q;
    elem_re = 1'b0; elem_raddr = i_q;
    pre_we  = 1'b0; pre_waddr  = idx_q; pre_wdata  = p_q;
    pre_re  = 1'b0; pre_raddr  = idx_q - 1'b1;
    res_we  = 1'b0; res_waddr  = i_q;   res_wdata  = arsp.rem;
    res_re  = 1'b0; res_raddr  = e_q;

    in_i.ready = (state_q == bmi_pkg::S_IDLE);

    case (state_q)
      bmi_pkg::S_IDLE: begin
        if (in_acc) begin
          v_d    = in_i.value;
          last_d = in_i.last_in;
          m_d    = modulus_q;
          ok_d   = (modulus_q >= VB'(2));
          idx_d  = count_q[IW-1:0];
          if (modulus_q >= VB'(2)) begin
            areq.start = 1'b1;
            areq.op    = bmi_pkg::OP_DIV;
            areq.x     = in_i.value;
            areq.y     = modulus_q;
            state_d    = bmi_pkg::S_RED_V_W;
          end else begin
            v_d     = '0;
            state_d = bmi_pkg::S_WR_ELEM;
          end
        end
      end
      bmi_pkg::S_RED_V_W: begin
        if (arsp.done) begin
          v_d     = arsp.rem;
          state_d = bmi_pkg::S_WR_ELEM;
        end
      end
      bmi_pkg::S_WR_ELEM: begin
        elem_we = 1'b1;
        if ((idx_q == '0) || !ok_q) begin
          p_d     = (idx_q == '0) ? v_q : '0;
          state_d = bmi_pkg::S_WR_PRE;
        end else begin
          pre_re  = 1'b1;
          state_d = bmi_pkg::S_PRE_RD;
        end
      end
      bmi_pkg::S_PRE_RD: begin
        areq.start = 1'b1;
        areq.op    = bmi_pkg::OP_DIV;
        areq.x     = pre_rdata_q;
        areq.y     = m_q;
        state_d    = bmi_pkg::S_RED_P_W;
      end
      bmi_pkg::S_RED_P_W: begin
        if (arsp.done) begin
          areq.start = 1'b1;
          areq.op    = bmi_pkg::OP_MUL;
          areq.x     = v_q;
          areq.y     = arsp.rem;
          state_d    = bmi_pkg::S_MUL_P_W;
        end
      end
      bmi_pkg::S_MUL_P_W: begin
        if (arsp.done) begin
          p_d     = arsp.rem;
          state_d = bmi_pkg::S_WR_PRE;
        end
      end
      bmi_pkg::S_WR_PRE: begin
        pre_we = 1'b1;
        if (!closing) begin
          count_d = bmi_pkg::COUNT_W'(idx_q) + 1'b1;
          state_d = bmi_pkg::S_IDLE;
        end else begin
          count_d = '0;
          i_d     = idx_q;
          e_d     = '0;
          if (!ok_q) begin
            err_d   = 1'b1;
            state_d = bmi_pkg::S_EMIT_RD;
          end else begin
            r0_d    = m_q;
            r1_d    = p_q;
            t0_d    = '0;
            t1_d    = VB'(1);
            state_d = bmi_pkg::S_INV_CHK;
          end
        end
      end
      bmi_pkg::S_INV_CHK: begin
        if (r1_q == '0) begin
          if (r0_q == VB'(1)) begin
            err_d   = 1'b0;
            aux_d   = t0_q;
            state_d = bmi_pkg::S_BK;
          end else begin
            err_d   = 1'b1;
            state_d = bmi_pkg::S_EMIT_RD;
          end
        end else begin
          areq.start = 1'b1;
          areq.op    = bmi_pkg::OP_DIV;
          areq.x     = r0_q;
          areq.y     = r1_q;
          state_d    = bmi_pkg::S_INV_DIV_W;
        end
      end
      bmi_pkg::S_INV_DIV_W: begin
        if (arsp.done) begin
          nr_d       = arsp.rem;
          areq.start = 1'b1;
          areq.op    = bmi_pkg::OP_MUL;
          areq.x     = arsp.quot;
          areq.y     = t1_q;
          state_d    = bmi_pkg::S_INV_MUL_W;
        end
      end
      bmi_pkg::S_INV_MUL_W: begin
        if (arsp.done) begin
          r0_d    = r1_q;
          r1_d    = nr_q;
          t0_d    = t1_q;
          t1_d    = nt;
          state_d = bmi_pkg::S_INV_CHK;
        end
      end
      bmi_pkg::S_BK: begin
        if (i_q == '0) begin
          res_we    = 1'b1;
          res_wdata = aux_q;
          state_d   = bmi_pkg::S_EMIT_RD;
        end else begin
          pre_re    = 1'b1;
          pre_raddr = i_q - 1'b1;
          state_d   = bmi_pkg::S_BK_PRD;
        end
      end
      bmi_pkg::S_BK_PRD: begin
        areq.start = 1'b1;
        areq.op    = bmi_pkg::OP_MUL;
        areq.x     = pre_rdata_q;
        areq.y     = aux_q;
        state_d    = bmi_pkg::S_BK_M1;
      end
      bmi_pkg::S_BK_M1: begin
        if (arsp.done) begin
          res_we  = 1'b1;
          elem_re = 1'b1;
          state_d = bmi_pkg::S_BK_ERD;
        end
      end
      bmi_pkg::S_BK_ERD: begin
        areq.start = 1'b1;
        areq.op    = bmi_pkg::OP_MUL;
        areq.x     = elem_rdata_q;
        areq.y     = aux_q;
        state_d    = bmi_pkg::S_BK_M2;
      end
      bmi_pkg::S_BK_M2: begin
        if (arsp.done) begin
          aux_d   = arsp.rem;
          i_d     = i_q - 1'b1;
          state_d = bmi_pkg::S_BK;
        end
      end
      bmi_pkg::S_EMIT_RD: begin
        res_re  = 1'b1;
        state_d = bmi_pkg::S_EMIT_LD;
      end
      bmi_pkg::S_EMIT_LD: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_inv_d   = err_q ? '0 : res_rdata_q;
          out_err_d   = err_q;
          out_last_d  = (e_q == idx_q);
          if (e_q == idx_q) begin
            state_d = bmi_pkg::S_IDLE;
          end else begin
            e_d     = e_q + 1'b1;
            state_d = bmi_pkg::S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = bmi_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bmi_pkg::S_IDLE;
      count_q     <= '0;
      modulus_q   <= bmi_pkg::MODULUS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      modulus_q   <= modulus_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    v_q <= v_d;  m_q <= m_d;  p_q <= p_d;
    r0_q <= r0_d; r1_q <= r1_d; t0_q <= t0_d; t1_q <= t1_d;
    nr_q <= nr_d; aux_q <= aux_d;
    last_q <= last_d; ok_q <= ok_d; err_q <= err_d;
    idx_q <= idx_d; i_q <= i_d; e_q <= e_d;
    out_inv_q  <= out_inv_d;
    out_err_q  <= out_err_d;
    out_last_q <= out_last_d;
  end

  // Element, prefix and result memories with registered read data.
  always_ff @(posedge clk_i) begin
    if (elem_we) elem_mem[elem_waddr] <= elem_wdata;
    if (elem_re) elem_rdata_q <= elem_mem[elem_raddr];
    if (pre_we)  pre_mem[pre_waddr] <= pre_wdata;
    if (pre_re)  pre_rdata_q <= pre_mem[pre_raddr];
    if (res_we)  res_mem[res_waddr] <= res_wdata;
    if (res_re)  res_rdata_q <= res_mem[res_raddr];
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.inverse        = out_inv_q;
  assign out_o.not_invertible = out_err_q;
  assign out_o.last_out       = out_last_q;

endmodule

`default_nettype wire
